/* rtl/ltdc_pkg.sv */
// Shared types and constants for the lock table with deadlock check.
package ltdc_pkg;

    localparam int PROC_W = 4;
    localparam int RES_W  = 6;

    typedef enum logic [1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_UNBLOCK = 2'd3
    } t_kind;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input item
        logic clr_wr;      // write one zero row of the lock table
        logic lk_rd_op;    // read lock row at the item's resource
        logic lk_rd_wait;  // read lock row at the waited-for resource
        logic wt_rd_slot;  // read wait entry of the scan slot
        logic wt_rd_own;   // read wait entry of the row's owner
        logic op_wr;       // commit an acquire or release
        logic unblk;       // clear the blocked flag of the item's process
        logic slot_clr;
        logic slot_inc;
        logic res_op;      // present the result of an acquire or release
        logic res_found;   // present a found pair
        logic res_none;    // present an all-zero result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  in_range;
        logic  clr_last;
        logic  slot_last;
        logic  slot_cand;
        logic  lk_valid;
        logic  own_cand;
        logic  mark_hit;
    } t_sts;

endpackage

/* rtl/ltdc_ram.sv */
// Generic RAM: one write port, one read port with registered read data.
module ltdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ltdc_ctrl.sv */
// Controller: sequences clearing, lock operations and the deadlock scan.
module ltdc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ltdc_pkg::t_sts  i_sts,
    output ltdc_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_OP_EX,
        S_CK_SLOT,
        S_CK_LK1,
        S_CK_OWN,
        S_CK_LK2,
        S_CK_MARK
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   adv;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        adv     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                    n_busy     = 1'b1;
                end
            end
            S_DECODE: begin
                priority if (i_sts.kind == ltdc_pkg::KIND_CHECK) begin
                    o_cmd.slot_clr = 1'b1;
                    n_state        = S_CK_SLOT;
                end else if (!i_sts.in_range) begin
                    o_cmd.res_none = 1'b1;
                    n_state        = S_IDLE;
                    n_busy         = 1'b0;
                end else if (i_sts.kind == ltdc_pkg::KIND_UNBLOCK) begin
                    o_cmd.unblk    = 1'b1;
                    o_cmd.res_none = 1'b1;
                    n_state        = S_IDLE;
                    n_busy         = 1'b0;
                end else begin
                    o_cmd.lk_rd_op = 1'b1;
                    n_state        = S_OP_EX;
                end
            end
            S_OP_EX: begin
                o_cmd.op_wr  = 1'b1;
                o_cmd.res_op = 1'b1;
                n_state      = S_IDLE;
                n_busy       = 1'b0;
            end
            S_CK_SLOT: begin
                if (i_sts.slot_cand) begin
                    o_cmd.wt_rd_slot = 1'b1;
                    n_state          = S_CK_LK1;
                end else begin
                    adv = 1'b1;
                end
            end
            S_CK_LK1: begin
                o_cmd.lk_rd_wait = 1'b1;
                n_state          = S_CK_OWN;
            end
            S_CK_OWN: begin
                if (i_sts.lk_valid && i_sts.own_cand) begin
                    o_cmd.wt_rd_own = 1'b1;
                    n_state         = S_CK_LK2;
                end else begin
                    adv = 1'b1;
                end
            end
            S_CK_LK2: begin
                o_cmd.lk_rd_wait = 1'b1;
                n_state          = S_CK_MARK;
            end
            S_CK_MARK: begin
                if (i_sts.mark_hit) begin
                    o_cmd.res_found = 1'b1;
                    n_state         = S_IDLE;
                    n_busy          = 1'b0;
                end else begin
                    adv = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase

        // move to the next slot, or finish the scan with nothing found
        if (adv) begin
            if (i_sts.slot_last) begin
                o_cmd.res_none = 1'b1;
                n_state        = S_IDLE;
                n_busy         = 1'b0;
            end else begin
                o_cmd.slot_inc = 1'b1;
                n_state        = S_CK_SLOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

/* rtl/ltdc_dp.sv */
// Datapath: lock table and wait RAMs, per-process flags and result registers.
module ltdc_dp #(
    parameter int PROCESS_SLOTS  = 16,
    parameter int RESOURCE_COUNT = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ltdc_pkg::t_cmd               i_cmd,
    output ltdc_pkg::t_sts               o_sts,
    input  logic [1:0]                   i_kind,
    input  logic [ltdc_pkg::PROC_W-1:0]  i_process,
    input  logic [ltdc_pkg::RES_W-1:0]   i_resource,
    output logic                         o_done,
    output logic                         o_granted,
    output logic                         o_deadlock_found,
    output logic [ltdc_pkg::PROC_W-1:0]  o_first_process,
    output logic [ltdc_pkg::PROC_W-1:0]  o_holder_process
);

    localparam int PW = $clog2(PROCESS_SLOTS);
    localparam int RW = $clog2(RESOURCE_COUNT);
    // lock row: {held marks per process, owner, valid}
    localparam int LW = PROCESS_SLOTS + ltdc_pkg::PROC_W + 1;

    ltdc_pkg::t_kind               r_kind;
    logic [ltdc_pkg::PROC_W-1:0]   r_proc;
    logic [ltdc_pkg::RES_W-1:0]    r_res;
    logic [PW-1:0]                 r_slot;
    logic [RW-1:0]                 r_clr;
    logic [ltdc_pkg::PROC_W-1:0]   r_own;
    logic [PROCESS_SLOTS-1:0]      r_blk;
    logic [PROCESS_SLOTS-1:0]      r_wv;

    logic                          r_done;
    logic                          r_granted;
    logic                          r_found;
    logic [ltdc_pkg::PROC_W-1:0]   r_first;
    logic [ltdc_pkg::PROC_W-1:0]   r_holder;

    logic [LW-1:0]                 lk_rdata, lk_wdata, row_new;
    logic [RW-1:0]                 lk_raddr, lk_waddr;
    logic                          lk_we, lk_re;
    logic [ltdc_pkg::RES_W-1:0]    wt_rdata;
    logic [PW-1:0]                 wt_raddr;
    logic                          wt_we, wt_re;

    logic                          lk_valid;
    logic [ltdc_pkg::PROC_W-1:0]   lk_owner;
    logic [PROCESS_SLOTS-1:0]      lk_marks, n_marks;
    logic [PW-1:0]                 p_idx, own_idx;
    logic                          is_acq, is_rel, proc_ok, res_ok;

    assign lk_valid = lk_rdata[0];
    assign lk_owner = lk_rdata[ltdc_pkg::PROC_W:1];
    assign lk_marks = lk_rdata[LW-1:ltdc_pkg::PROC_W+1];
    assign p_idx    = PW'(r_proc);
    assign own_idx  = PW'(lk_owner);
    assign is_acq   = (r_kind == ltdc_pkg::KIND_ACQUIRE);
    assign is_rel   = (r_kind == ltdc_pkg::KIND_RELEASE);
    assign proc_ok  = (32'(r_proc) < PROCESS_SLOTS);
    assign res_ok   = (32'(r_res) < RESOURCE_COUNT);

    always_comb begin
        n_marks        = lk_marks;
        n_marks[p_idx] = is_acq;
        row_new        = {n_marks, (is_acq ? r_proc : lk_owner), is_acq};
    end

    // lock table port selection
    assign lk_re    = i_cmd.lk_rd_op | i_cmd.lk_rd_wait;
    assign lk_raddr = i_cmd.lk_rd_wait ? RW'(wt_rdata) : RW'(r_res);
    assign lk_we    = i_cmd.clr_wr | (i_cmd.op_wr & ((is_acq & ~lk_valid) | is_rel));
    assign lk_waddr = i_cmd.clr_wr ? r_clr : RW'(r_res);
    assign lk_wdata = i_cmd.clr_wr ? '0 : row_new;

    // wait RAM: written on a refused acquire, read during the scan
    assign wt_we    = i_cmd.op_wr & is_acq & lk_valid;
    assign wt_re    = i_cmd.wt_rd_slot | i_cmd.wt_rd_own;
    assign wt_raddr = i_cmd.wt_rd_own ? own_idx : r_slot;

    ltdc_ram #(
        .WIDTH (LW),
        .DEPTH (RESOURCE_COUNT)
    ) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    ltdc_ram #(
        .WIDTH (ltdc_pkg::RES_W),
        .DEPTH (PROCESS_SLOTS)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (p_idx),
        .i_wdata (r_res),
        .i_re    (wt_re),
        .i_raddr (wt_raddr),
        .o_rdata (wt_rdata)
    );

    // item capture and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= ltdc_pkg::t_kind'(i_kind);
            r_proc <= i_process;
            r_res  <= i_resource;
        end
        if (i_cmd.slot_clr) begin
            r_slot <= '0;
        end else if (i_cmd.slot_inc) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.wt_rd_own) begin
            r_own <= lk_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_blk     <= '0;
            r_wv      <= '0;
            r_done    <= 1'b0;
            r_granted <= 1'b0;
            r_found   <= 1'b0;
            r_first   <= '0;
            r_holder  <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.unblk) begin
                r_blk[p_idx] <= 1'b0;
            end
            if (i_cmd.op_wr && is_acq) begin
                if (lk_valid) begin
                    r_blk[p_idx] <= 1'b1;
                    r_wv[p_idx]  <= 1'b1;
                end else begin
                    r_wv[p_idx]  <= 1'b0;
                end
            end
            r_done <= i_cmd.res_op | i_cmd.res_found | i_cmd.res_none;
            // hold the last result when no result command is given
            if (i_cmd.res_op) begin
                r_granted <= is_acq & ~lk_valid;
                r_found   <= 1'b0;
                r_first   <= '0;
                r_holder  <= (is_acq & lk_valid) ? lk_owner : '0;
            end else if (i_cmd.res_found) begin
                r_granted <= 1'b0;
                r_found   <= 1'b1;
                r_first   <= ltdc_pkg::PROC_W'(r_slot);
                r_holder  <= r_own;
            end else if (i_cmd.res_none) begin
                r_granted <= 1'b0;
                r_found   <= 1'b0;
                r_first   <= '0;
                r_holder  <= '0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.kind      = r_kind;
        o_sts.in_range  = (r_kind == ltdc_pkg::KIND_UNBLOCK) ? proc_ok : (proc_ok & res_ok);
        o_sts.clr_last  = (r_clr == RW'(RESOURCE_COUNT - 1));
        o_sts.slot_last = (r_slot == PW'(PROCESS_SLOTS - 1));
        o_sts.slot_cand = r_blk[r_slot] & r_wv[r_slot];
        o_sts.lk_valid  = lk_valid;
        o_sts.own_cand  = r_blk[own_idx] & r_wv[own_idx];
        o_sts.mark_hit  = lk_marks[r_slot];
    end

    assign o_done           = r_done;
    assign o_granted        = r_granted;
    assign o_deadlock_found = r_found;
    assign o_first_process  = r_first;
    assign o_holder_process = r_holder;

endmodule

/* rtl/lock_table_deadlock_check_top.sv */
// Top level: lock table with two-party deadlock check.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  item in  | i_start, o_busy        | i_kind, i_process, i_resource
//  result   | o_done (one cycle)     | o_granted, o_deadlock_found, o_first_process,
//           |                        | o_holder_process
//
//  An item transfers when i_start is high and o_busy is low; one result follows.
//  Acquire and release read the lock table row, then write it back or, for a refused
//  acquire, write the wait RAM; unblock and out-of-range items skip the tables.
//  A deadlock check walks the process slots one at a time through the lock table and
//  wait RAM, each with one read port, and stops at the first pair found.
//  After reset the lock table is swept clear row by row, with o_busy high.
//  Results cannot be stalled; o_done marks each one for exactly one cycle.
module lock_table_deadlock_check_top #(
    parameter int PROCESS_SLOTS  = 16,
    parameter int RESOURCE_COUNT = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_kind,
    input  logic [ltdc_pkg::PROC_W-1:0]  i_process,
    input  logic [ltdc_pkg::RES_W-1:0]   i_resource,
    output logic                         o_done,
    output logic                         o_granted,
    output logic                         o_deadlock_found,
    output logic [ltdc_pkg::PROC_W-1:0]  o_first_process,
    output logic [ltdc_pkg::PROC_W-1:0]  o_holder_process
);

    ltdc_pkg::t_cmd cmd;
    ltdc_pkg::t_sts sts;

    ltdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ltdc_dp #(
        .PROCESS_SLOTS  (PROCESS_SLOTS),
        .RESOURCE_COUNT (RESOURCE_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_process        (i_process),
        .i_resource       (i_resource),
        .o_done           (o_done),
        .o_granted        (o_granted),
        .o_deadlock_found (o_deadlock_found),
        .o_first_process  (o_first_process),
        .o_holder_process (o_holder_process)
    );

    // a transfer raises o_busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after a transfer");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without a transfer in progress");

    // a grant and a found pair never share a result
    a_grant_or_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_granted && o_deadlock_found))
        else $error("grant and deadlock reported together");

    // the clearing sweep never overlaps another lock table access
    a_one_lock_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clr_wr && (cmd.op_wr || cmd.lk_rd_op || cmd.lk_rd_wait)))
        else $error("clearing sweep overlaps a lock table access");

endmodule
